// ----- sv/hrtp_pkg.sv -----
`default_nettype none
package hrtp_pkg;

  // Field widths fixed by the block's interface.
  localparam int unsigned CoordW    = 32;
  localparam int unsigned TileSizeW = 31;
  localparam int unsigned FloorW    = 4;
  localparam int unsigned EpsW      = 16;
  localparam int unsigned CellIdxW  = 12;
  localparam int unsigned TileW     = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned StoreDepth = 4096;

  // Drop values are capped at 2^40 raw units.
  localparam logic [40:0] DropCap = 41'h100_0000_0000;

  // Register map of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WORLD_MIN_X = 3'd0,
    CFG_WORLD_MIN_Y = 3'd1,
    CFG_TILE_SIZE   = 3'd2,
    CFG_MAX_FLOORS  = 3'd3,
    CFG_DIR_EPS     = 3'd4
  } cfg_reg_e;

  // Item kinds on the input channel.
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_PICK  = 1'b1
  } kind_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_US_MUL,
    ST_US,
    ST_PT_MUL,
    ST_PT_DIV,
    ST_PT_POS,
    ST_PT_CELL,
    ST_WK_READ,
    ST_DR_START,
    ST_DR_Q,
    ST_DR_QA,
    ST_DR_RA,
    ST_DR_V,
    ST_DECIDE,
    ST_DONE
  } seq_state_e;

  // Request and response of the shared divider.
  typedef struct packed {
    logic        go;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  // Clamp a tile index to the signed 16-bit output range.
  function automatic logic signed [TileW-1:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[TileW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- sv/hrtp_if.sv -----
`default_nettype none
// Input channel: column writes and pick rays.
interface hrtp_pick_if import hrtp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [CellIdxW-1:0]        cell_index;
  logic [FloorW-1:0]          cell_floors;
  logic signed [CoordW-1:0]   origin_x;
  logic signed [CoordW-1:0]   origin_y;
  logic signed [CoordW-1:0]   origin_z;
  logic signed [CoordW-1:0]   dir_x;
  logic signed [CoordW-1:0]   dir_y;
  logic signed [CoordW-1:0]   dir_z;

  modport source (output valid, kind, cell_index, cell_floors, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, kind, cell_index, cell_floors, origin_x, origin_y, origin_z,
                dir_x, dir_y, dir_z, output ready);
endinterface

// Result channel: one word per pick.
interface hrtp_result_if import hrtp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [TileW-1:0]  tile_x;
  logic signed [TileW-1:0]  tile_y;
  logic                     on_column;

  modport source (output valid, found, tile_x, tile_y, on_column, input ready);
  modport sink (input valid, found, tile_x, tile_y, on_column, output ready);
endinterface

// Configuration write channel.
interface hrtp_cfg_if import hrtp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/heightfield_ray_tile_pick.sv -----
`default_nettype none
// Tile picker over a grid of column heights. A write word stores a column
// height. A pick word casts a downward ray and returns one result word: the
// first tile whose column reaches the ray's exit altitude, else the ground
// tile under the ray. Divisions run on one shared 64/32 divider that yields
// one quotient bit a cycle, and the setup and edge-distance products on one
// shared 34x34 multiplier, stepped by a sequencer. After a pick word is
// accepted the block is not ready while it works out the start altitude,
// then four pairs of divisions for the ground and start points, then for
// each tested tile, up to MAX_WALK_STEPS, a store read, up to two divisions
// for each stepping axis and a decision, and while it hands the result word
// to the output register, which waits until that register is free; a ray
// that does not point downward goes straight to the hand-over. After reset
// the height store is cleared one entry a cycle, min(GRID_COLS*GRID_ROWS,
// 4096) entries in all, during which no word is accepted; configuration
// writes are taken at any time.
module heightfield_ray_tile_pick import hrtp_pkg::*; #(
  parameter int unsigned GRID_COLS      = 64,
  parameter int unsigned GRID_ROWS      = 64,
  parameter int unsigned MAX_WALK_STEPS = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  hrtp_pick_if.sink      pick_i,
  hrtp_result_if.source  result_o,
  hrtp_cfg_if.sink       cfg_i
);

  localparam int unsigned GridCells = GRID_COLS * GRID_ROWS;
  localparam int unsigned Cells     = (GridCells < StoreDepth) ? GridCells : StoreDepth;
  localparam int unsigned AddrW     = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned StepW     = $clog2(MAX_WALK_STEPS + 1);

  // Configuration registers.
  logic signed [CoordW-1:0] wmin_x_q, wmin_y_q;
  logic [TileSizeW-1:0]     tsize_q;
  logic [FloorW-1:0]        mcf_q;
  logic [EpsW-1:0]          eps_q;
  logic [TileSizeW-1:0]     ts_eff;

  // Control state.
  seq_state_e        state_q, state_d;
  logic [AddrW:0]    clr_cnt_q;
  logic [1:0]        pt_q;
  logic              ax_q;
  logic [StepW-1:0]  step_cnt_q;
  logic              out_valid_q;

  // Ray and walk payload.
  logic signed [CoordW-1:0] ox_q, oy_q, oz_q, dx_q, dy_q;
  logic [31:0]              a_q, us_q, mx_q, my_q;
  logic                     stx_en_q, stx_neg_q, sty_en_q, sty_neg_q;
  logic signed [63:0]       gtx_q, gty_q, cx_q, cy_q, lox_q, loy_q, p_q;
  logic                     pt_neg_q, tile_neg_q;
  logic [40:0]              nx_q, ny_q;
  logic [64:0]              qa_q;
  logic                     in_grid_q;
  logic                     res_found_q, res_on_q;
  logic signed [TileW-1:0]  res_tx_q, res_ty_q;
  logic                     out_found_q, out_on_q;
  logic signed [TileW-1:0]  out_tx_q, out_ty_q;

  // Shared multiplier.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             pick_fire;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [FloorW-1:0] ram_wdata, ram_rdata;
  logic             clr_last;

  function automatic logic signed [63:0] floor_q(input logic neg, input logic [63:0] q,
                                                 input logic [31:0] r);
    if (neg) begin
      return -($signed(q) + $signed({63'b0, r != 32'd0}));
    end else begin
      return $signed(q);
    end
  endfunction

  function automatic logic in_grid(input logic signed [63:0] gx, input logic signed [63:0] gy);
    return !gx[63] && (gx < $signed(64'(GRID_COLS))) &&
           !gy[63] && (gy < $signed(64'(GRID_ROWS)));
  endfunction

  assign ts_eff    = (tsize_q == '0) ? TileSizeW'(1) : tsize_q;
  assign pick_fire = pick_i.valid && pick_i.ready;
  assign pick_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign clr_last  = (clr_cnt_q == (AddrW+1)'(Cells - 1));

  // Configuration writes; indexes beyond the map are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wmin_x_q <= '0;
      wmin_y_q <= '0;
      tsize_q  <= TileSizeW'(6553600);
      mcf_q    <= FloorW'(15);
      eps_q    <= EpsW'(7);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WORLD_MIN_X: wmin_x_q <= cfg_i.data;
        CFG_WORLD_MIN_Y: wmin_y_q <= cfg_i.data;
        CFG_TILE_SIZE:   tsize_q  <= cfg_i.data[TileSizeW-1:0];
        CFG_MAX_FLOORS:  mcf_q    <= cfg_i.data[FloorW-1:0];
        CFG_DIR_EPS:     eps_q    <= cfg_i.data[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // Point setup: floor division results for the current point and axis.
  logic signed [CoordW-1:0] pt_o, pt_wmin;
  logic signed [63:0]       pos_p, pos_n, tile_fq, tile_lo;
  logic [63:0]              prod_mag, n_mag;
  logic [31:0]              tile_remf;

  assign pt_o     = pt_q[0] ? oy_q : ox_q;
  assign pt_wmin  = pt_q[0] ? wmin_y_q : wmin_x_q;
  assign prod_mag = prod_q[67] ? (~prod_q[63:0]) + 64'd1 : prod_q[63:0];
  assign pos_p    = 64'(pt_o) + floor_q(pt_neg_q, div_rsp.quot, div_rsp.rem);
  assign pos_n    = pos_p - 64'(pt_wmin);
  assign n_mag    = pos_n[63] ? (~pos_n) + 64'd1 : pos_n;
  assign tile_fq  = floor_q(tile_neg_q, div_rsp.quot, div_rsp.rem);
  assign tile_remf = (tile_neg_q && div_rsp.rem != 32'd0) ? 32'(ts_eff) - div_rsp.rem :
                     (tile_neg_q ? 32'd0 : div_rsp.rem);
  assign tile_lo  = p_q - $signed(64'(tile_remf));

  // Edge crossing distance on the current axis.
  logic signed [CoordW-1:0] ax_o;
  logic signed [63:0]       ax_lo, edge_span;
  logic [63:0]              dist_u;
  logic [31:0]              ax_mag;
  logic                     ax_en, ax_neg, quot_big;
  logic [65:0]              drop_sum;
  logic [40:0]              drop_v;

  assign ax_o   = ax_q ? oy_q : ox_q;
  assign ax_lo  = ax_q ? loy_q : lox_q;
  assign ax_en  = ax_q ? sty_en_q : stx_en_q;
  assign ax_neg = ax_q ? sty_neg_q : stx_neg_q;
  assign ax_mag = ax_q ? my_q : mx_q;
  assign edge_span = ax_neg ? (64'(ax_o) - ax_lo) :
                              (ax_lo + $signed(64'(ts_eff)) - 64'(ax_o));
  assign dist_u = edge_span[63] ? 64'd0 : edge_span;
  assign quot_big = (|div_rsp.quot[63:33]) || (div_rsp.quot[32] && |div_rsp.quot[31:0]);
  assign drop_sum = 66'(qa_q) + 66'(div_rsp.quot);
  assign drop_v   = (drop_sum > 66'(DropCap)) ? DropCap : drop_sum[40:0];

  // Tile test at the exit altitude.
  logic [40:0]        ex_min;
  logic signed [43:0] oz_w, ex_w, alt_w, top_w;
  logic [34:0]        top;
  logic [FloorW-1:0]  floors_eff;
  logic               caught, brk, last_step, step_x;

  assign ex_min     = (nx_q < ny_q) ? nx_q : ny_q;
  assign oz_w       = 44'(oz_q);
  assign ex_w       = (oz_w < $signed({3'b0, ex_min})) ? oz_w : $signed({3'b0, ex_min});
  assign alt_w      = oz_w - ex_w;
  assign floors_eff = in_grid_q ? ram_rdata : '0;
  assign top        = 35'(floors_eff) * 35'(ts_eff);
  assign top_w      = $signed({9'b0, top});
  assign caught     = (top != '0) && (top_w >= alt_w);
  assign brk        = ex_w >= oz_w;
  assign last_step  = step_cnt_q == StepW'(MAX_WALK_STEPS - 1);
  assign step_x     = nx_q < ny_q;

  // Store address of the current tile.
  logic [31:0] rd_idx;
  logic        rd_ok;
  assign rd_idx = 32'(cy_q[15:0]) * 32'(GRID_COLS) + 32'(cx_q[15:0]);
  assign rd_ok  = in_grid(cx_q, cy_q) && (rd_idx < 32'(Cells));

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_US_MUL: begin
        mul_a = 34'(mcf_q);
        mul_b = 34'(ts_eff);
      end
      ST_PT_MUL: begin
        mul_a = 34'(pt_q[0] ? dy_q : dx_q);
        mul_b = pt_q[1] ? $signed({2'b0, us_q}) : 34'(oz_q);
      end
      ST_DR_Q: begin
        mul_a = $signed({1'b0, div_rsp.quot[32:0]});
        mul_b = $signed({2'b0, a_q});
      end
      ST_DR_QA: begin
        mul_a = $signed({2'b0, div_rsp.rem});
        mul_b = $signed({2'b0, a_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Sequencer next state and divider requests.
  always_comb begin
    state_d = state_q;
    div_req = '0;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (pick_fire && pick_i.kind == KIND_PICK) begin
          state_d = pick_i.dir_z[31] ? ST_US_MUL : ST_DONE;
        end
      end
      ST_US_MUL: state_d = ST_US;
      ST_US:     state_d = ST_PT_MUL;
      ST_PT_MUL: state_d = ST_PT_DIV;
      ST_PT_DIV: begin
        div_req.go       = 1'b1;
        div_req.dividend = prod_mag;
        div_req.divisor  = a_q;
        state_d          = ST_PT_POS;
      end
      ST_PT_POS: begin
        if (div_rsp.done) begin
          div_req.go       = 1'b1;
          div_req.dividend = n_mag;
          div_req.divisor  = 32'(ts_eff);
          state_d          = ST_PT_CELL;
        end
      end
      ST_PT_CELL: begin
        if (div_rsp.done) state_d = (pt_q == 2'd3) ? ST_WK_READ : ST_PT_MUL;
      end
      ST_WK_READ: state_d = ST_DR_START;
      ST_DR_START: begin
        if (!ax_en) begin
          state_d = ax_q ? ST_DECIDE : ST_DR_START;
        end else begin
          div_req.go       = 1'b1;
          div_req.dividend = dist_u;
          div_req.divisor  = ax_mag;
          state_d          = ST_DR_Q;
        end
      end
      ST_DR_Q: begin
        if (div_rsp.done) begin
          if (quot_big) state_d = ax_q ? ST_DECIDE : ST_DR_START;
          else state_d = ST_DR_QA;
        end
      end
      ST_DR_QA: state_d = ST_DR_RA;
      ST_DR_RA: begin
        div_req.go       = 1'b1;
        div_req.dividend = prod_q[63:0];
        div_req.divisor  = ax_mag;
        state_d          = ST_DR_V;
      end
      ST_DR_V: begin
        if (div_rsp.done) state_d = ax_q ? ST_DECIDE : ST_DR_START;
      end
      ST_DECIDE: state_d = (caught || brk || last_step) ? ST_DONE : ST_WK_READ;
      ST_DONE:   if (!out_valid_q || result_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      pt_q        <= '0;
      ax_q        <= 1'b0;
      step_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + (AddrW+1)'(1);
      if (state_q == ST_US) pt_q <= '0;
      if (state_q == ST_PT_CELL && div_rsp.done) pt_q <= pt_q + 2'd1;
      if (state_q == ST_WK_READ) ax_q <= 1'b0;
      if ((state_q == ST_DR_START && !ax_en) || (state_q == ST_DR_Q && div_rsp.done && quot_big)
          || (state_q == ST_DR_V && div_rsp.done)) begin
        ax_q <= 1'b1;
      end
      if (state_q == ST_US) step_cnt_q <= '0;
      if (state_q == ST_DECIDE) step_cnt_q <= step_cnt_q + StepW'(1);
      if (result_o.ready) out_valid_q <= 1'b0;
      if (state_q == ST_DONE && (!out_valid_q || result_o.ready)) out_valid_q <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (pick_fire) begin
          ox_q      <= pick_i.origin_x;
          oy_q      <= pick_i.origin_y;
          oz_q      <= pick_i.origin_z;
          dx_q      <= pick_i.dir_x;
          dy_q      <= pick_i.dir_y;
          a_q       <= (~pick_i.dir_z) + 32'd1;
          mx_q      <= pick_i.dir_x[31] ? (~pick_i.dir_x) + 32'd1 : pick_i.dir_x;
          my_q      <= pick_i.dir_y[31] ? (~pick_i.dir_y) + 32'd1 : pick_i.dir_y;
          stx_neg_q <= pick_i.dir_x[31];
          sty_neg_q <= pick_i.dir_y[31];
          res_found_q <= 1'b0;
          res_on_q    <= 1'b0;
          res_tx_q    <= '0;
          res_ty_q    <= '0;
        end
      end
      ST_US_MUL: begin
        stx_en_q <= mx_q > 32'(eps_q);
        sty_en_q <= my_q > 32'(eps_q);
      end
      ST_US: begin
        us_q <= (36'(oz_q) < $signed(prod_q[35:0])) ? 32'd0 : 32'(36'(oz_q) - prod_q[35:0]);
      end
      ST_PT_DIV: pt_neg_q <= prod_q[67];
      ST_PT_POS: begin
        if (div_rsp.done) begin
          p_q        <= pos_p;
          tile_neg_q <= pos_n[63];
        end
      end
      ST_PT_CELL: begin
        if (div_rsp.done) begin
          unique case (pt_q)
            2'd0: gtx_q <= tile_fq;
            2'd1: gty_q <= tile_fq;
            2'd2: begin
              cx_q  <= tile_fq;
              lox_q <= tile_lo;
            end
            default: begin
              cy_q  <= tile_fq;
              loy_q <= tile_lo;
            end
          endcase
        end
      end
      ST_WK_READ: in_grid_q <= rd_ok;
      ST_DR_START: begin
        if (!ax_en) begin
          if (ax_q) ny_q <= DropCap;
          else nx_q <= DropCap;
        end
      end
      ST_DR_Q: begin
        if (div_rsp.done && quot_big) begin
          if (ax_q) ny_q <= DropCap;
          else nx_q <= DropCap;
        end
      end
      ST_DR_QA: qa_q <= prod_q[64:0];
      ST_DR_V: begin
        if (div_rsp.done) begin
          if (ax_q) ny_q <= drop_v;
          else nx_q <= drop_v;
        end
      end
      ST_DECIDE: begin
        if (caught) begin
          res_found_q <= 1'b1;
          res_on_q    <= 1'b1;
          res_tx_q    <= sat16(cx_q);
          res_ty_q    <= sat16(cy_q);
        end else if (brk || last_step) begin
          res_found_q <= in_grid(gtx_q, gty_q);
          res_on_q    <= 1'b0;
          res_tx_q    <= sat16(gtx_q);
          res_ty_q    <= sat16(gty_q);
        end else if (step_x) begin
          if (stx_en_q) begin
            cx_q  <= stx_neg_q ? cx_q - 64'sd1 : cx_q + 64'sd1;
            lox_q <= stx_neg_q ? lox_q - $signed(64'(ts_eff)) : lox_q + $signed(64'(ts_eff));
          end
        end else if (sty_en_q) begin
          cy_q  <= sty_neg_q ? cy_q - 64'sd1 : cy_q + 64'sd1;
          loy_q <= sty_neg_q ? loy_q - $signed(64'(ts_eff)) : loy_q + $signed(64'(ts_eff));
        end
      end
      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_found_q <= res_found_q;
          out_on_q    <= res_on_q;
          out_tx_q    <= res_tx_q;
          out_ty_q    <= res_ty_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.found     = out_found_q;
  assign result_o.tile_x    = out_tx_q;
  assign result_o.tile_y    = out_ty_q;
  assign result_o.on_column = out_on_q;

  // Height store: clearing pass after reset, then column writes and walk reads.
  assign ram_we    = (state_q == ST_CLEAR) ||
                     (pick_fire && pick_i.kind == KIND_WRITE &&
                      (32'(pick_i.cell_index) < 32'(Cells)));
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q[AddrW-1:0] : pick_i.cell_index[AddrW-1:0];
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : pick_i.cell_floors;
  assign ram_re    = (state_q == ST_WK_READ);
  assign ram_raddr = rd_idx[AddrW-1:0];

  hrtp_ram #(
    .Width (FloorW),
    .Depth (Cells)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hrtp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The sequencer only starts a division when the divider is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_req.go |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The walk never tests more tiles than the step limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (step_cnt_q < StepW'(MAX_WALK_STEPS)))
    else $error("walk step count beyond limit");

  // An accepted pick always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pick_fire && pick_i.kind == KIND_PICK) |=> (state_q != ST_IDLE))
    else $error("pick accepted without starting work");

  // A new result is only loaded when the output register is free or drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |-> (!out_valid_q || result_o.ready))
    else $error("result word overwritten");

endmodule
`default_nettype wire

// ----- sv/hrtp_ram.sv -----
`default_nettype none
module hrtp_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/hrtp_div.sv -----
`default_nettype none
module hrtp_div import hrtp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] trial;
  logic        fits;

  // One quotient bit per cycle by restoring division.
  assign trial = {rem_q, quo_q[63]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire
